// ----- rtl/core/button_click_classifier_defines.svh -----
// Assertion helpers shared by the RTL.
`ifndef BUTTON_CLICK_CLASSIFIER_DEFINES_SVH
`define BUTTON_CLICK_CLASSIFIER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BCC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BCC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/bcc_pkg.sv -----
package bcc_pkg;

    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [CFG_IDX_BITS-1:0] CFG_PRESSED_LEVEL   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DEBOUNCE_MS     = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ARM_MS          = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DBL_GAP_MS      = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LONG_CLICK_MS   = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_REPEAT_GAP_MS   = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SUPPRESS_LONG   = 3'd6;

    // bit positions in the single-click flag word
    localparam int SF_PREVENT = 0;
    localparam int SF_WAIT    = 1;
    localparam int SF_PENDING = 2;

    localparam logic [2:0] DBL_COUNT_MAX = 3'd7;

    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_CLICK  = 2'd1,
        EV_DOUBLE = 2'd2,
        EV_LONG   = 2'd3
    } t_event;

    typedef struct packed {
        logic        pressed_level;
        logic [15:0] debounce_ms;
        logic [15:0] arm_ms;
        logic [15:0] dbl_gap_ms;
        logic [15:0] long_click_ms;
        logic [15:0] repeat_gap_ms;
        logic        suppress_long;
    } t_cfg;

endpackage

// ----- rtl/core/bcc_cfg.sv -----
module bcc_cfg
    import bcc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    output t_cfg                     o_cfg
);

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pressed_level   <= 1'b0;
            r_cfg.debounce_ms     <= 16'd20;
            r_cfg.arm_ms          <= 16'd80;
            r_cfg.dbl_gap_ms      <= 16'd30;
            r_cfg.long_click_ms   <= 16'd800;
            r_cfg.repeat_gap_ms   <= 16'd400;
            r_cfg.suppress_long   <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_PRESSED_LEVEL:   r_cfg.pressed_level   <= i_cfg_data[0];
                CFG_DEBOUNCE_MS:     r_cfg.debounce_ms     <= i_cfg_data;
                CFG_ARM_MS:          r_cfg.arm_ms          <= i_cfg_data;
                CFG_DBL_GAP_MS:      r_cfg.dbl_gap_ms      <= i_cfg_data;
                CFG_LONG_CLICK_MS:   r_cfg.long_click_ms   <= i_cfg_data;
                CFG_REPEAT_GAP_MS:   r_cfg.repeat_gap_ms   <= i_cfg_data;
                CFG_SUPPRESS_LONG:   r_cfg.suppress_long   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

endmodule

// ----- rtl/core/bcc_core.sv -----
module bcc_core
    import bcc_pkg::*;
#(
    parameter int TIME_BITS = 32
)(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cfg                 i_cfg,
    input  logic                 i_fire,
    input  logic                 i_level,
    input  logic [TIME_BITS-1:0] i_now,
    output t_event               o_event
);

    logic                 r_stable_level, n_stable_level;
    logic [TIME_BITS-1:0] r_change_time, n_change_time;
    logic [TIME_BITS-1:0] r_press_start, n_press_start;
    logic                 r_press_valid, n_press_valid;
    logic [TIME_BITS-1:0] r_repeat_due, n_repeat_due;
    logic                 r_repeat_valid, n_repeat_valid;
    logic [TIME_BITS-1:0] r_release_time, n_release_time;
    logic                 r_release_valid, n_release_valid;
    logic [2:0]           r_double_count, n_double_count;
    logic [2:0]           r_flags, n_flags;
    logic [TIME_BITS-1:0] r_single_after, n_single_after;
    logic [TIME_BITS-1:0] r_click_nb, n_click_nb;
    logic                 r_long_latch, n_long_latch;

    logic [TIME_BITS-1:0] held, since_change, since_release;
    logic [TIME_BITS-1:0] debounce_t, click_t, dbl_t, long_t;
    logic [TIME_BITS-1:0] repeat_at, click_at, single_at;
    logic                 reject, first_press, cond_long, cond_single, cond_dbl;
    t_event               ev;

    assign debounce_t    = TIME_BITS'(i_cfg.debounce_ms);
    assign click_t       = TIME_BITS'(i_cfg.arm_ms);
    assign dbl_t         = TIME_BITS'(i_cfg.dbl_gap_ms);
    assign long_t        = TIME_BITS'(i_cfg.long_click_ms);
    assign held          = i_now - r_press_start;
    assign since_change  = i_now - r_change_time;
    assign since_release = i_now - r_release_time;
    assign repeat_at     = i_now + TIME_BITS'(i_cfg.repeat_gap_ms);
    assign click_at      = i_now + TIME_BITS'(i_cfg.arm_ms >> 1);
    assign single_at     = i_now + TIME_BITS'({i_cfg.dbl_gap_ms, 1'b0});

    assign reject      = (i_level != r_stable_level) && (since_change < debounce_t);
    assign cond_long   = (held > long_t) && (!r_repeat_valid || i_now > r_repeat_due);
    assign cond_single = (held > click_t) && !r_flags[SF_WAIT] && !r_flags[SF_PREVENT]
                         && (i_now > r_single_after);
    assign cond_dbl    = (held > dbl_t) && !r_flags[SF_WAIT];

    always_comb begin
        n_stable_level  = r_stable_level;
        n_change_time   = r_change_time;
        n_press_start   = r_press_start;
        n_press_valid   = r_press_valid;
        n_repeat_due    = r_repeat_due;
        n_repeat_valid  = r_repeat_valid;
        n_release_time  = r_release_time;
        n_release_valid = r_release_valid;
        n_double_count  = r_double_count;
        n_flags         = r_flags;
        n_single_after  = r_single_after;
        n_click_nb      = r_click_nb;
        n_long_latch    = r_long_latch;
        first_press     = 1'b0;
        ev              = EV_NONE;

        if (!reject) begin
            n_stable_level = i_level;
            n_change_time  = i_now;
            if (i_level == i_cfg.pressed_level) begin
                if (!r_press_valid) begin
                    n_press_start = i_now;
                    n_press_valid = 1'b1;
                    first_press   = 1'b1;
                end else if (cond_long) begin
                    n_repeat_due           = repeat_at;
                    n_repeat_valid         = 1'b1;
                    n_double_count         = 3'd0;
                    n_long_latch           = 1'b1;
                    n_flags[SF_PREVENT]    = 1'b1;
                    n_flags[SF_PENDING]    = 1'b1;
                end else if (cond_single) begin
                    n_flags[SF_WAIT]    = 1'b1;
                    n_flags[SF_PENDING] = 1'b1;
                    n_click_nb          = click_at;
                end else if (cond_dbl) begin
                    if (r_release_valid && since_release > dbl_t) begin
                        n_single_after = single_at;
                        if (r_double_count < DBL_COUNT_MAX) begin
                            n_double_count = r_double_count + 3'd1;
                        end
                    end
                    n_release_valid = 1'b0;
                end
            end else begin
                if (i_now > r_click_nb && r_flags[SF_PENDING]) begin
                    n_double_count = 3'd0;
                    ev             = EV_CLICK;
                end
                n_release_time  = i_now;
                n_release_valid = 1'b1;
                n_press_valid   = 1'b0;
                n_repeat_valid  = 1'b0;
                n_flags         = 3'd0;
                n_long_latch    = 1'b0;
            end

            if (!first_press) begin
                if (n_flags[SF_PENDING] && n_double_count > 3'd1) begin
                    n_double_count      = 3'd0;
                    n_flags[SF_PREVENT] = 1'b0;
                    n_single_after      = '0;
                    ev                  = EV_DOUBLE;
                end
                // long press wins over a double click in the same sample
                if (n_long_latch && !i_cfg.suppress_long && n_flags[SF_PENDING]) begin
                    n_flags[SF_PREVENT] = 1'b1;
                    n_flags[SF_PENDING] = 1'b0;
                    n_repeat_due        = repeat_at;
                    n_repeat_valid      = 1'b1;
                    ev                  = EV_LONG;
                end
            end
        end
    end

    assign o_event = ev;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stable_level  <= 1'b0;
            r_change_time   <= '0;
            r_press_start   <= '0;
            r_press_valid   <= 1'b0;
            r_repeat_due    <= '0;
            r_repeat_valid  <= 1'b0;
            r_release_time  <= '0;
            r_release_valid <= 1'b0;
            r_double_count  <= 3'd0;
            r_flags         <= 3'd0;
            r_single_after  <= '0;
            r_click_nb      <= '0;
            r_long_latch    <= 1'b0;
        end else if (i_fire) begin
            r_stable_level  <= n_stable_level;
            r_change_time   <= n_change_time;
            r_press_start   <= n_press_start;
            r_press_valid   <= n_press_valid;
            r_repeat_due    <= n_repeat_due;
            r_repeat_valid  <= n_repeat_valid;
            r_release_time  <= n_release_time;
            r_release_valid <= n_release_valid;
            r_double_count  <= n_double_count;
            r_flags         <= n_flags;
            r_single_after  <= n_single_after;
            r_click_nb      <= n_click_nb;
            r_long_latch    <= n_long_latch;
        end
    end

endmodule

// ----- rtl/core/button_click_classifier.sv -----
// Button click classifier.
// Input channel (i_in_valid / o_in_ready): one item per pin sample, the raw level
// i_level and a wrapping millisecond timestamp i_now_ms.
// Output channel (o_out_valid / i_out_ready): exactly one item per sample,
// o_event_res = none, click, double click or long press.
// Config channel (i_cfg_valid / o_cfg_ready): register index and 16-bit data;
// always ready; the user must write it only while no sample is in flight,
// which the block itself does not enforce. Each sample is held in the input
// register, then its result is registered in the result register.
// Throughput: one item per cycle while the receiver keeps up; the classifier is
// a single pass of compares and adds between the two registers.
// A stalled receiver holds the result register; the input register keeps
// taking one more item, after which o_in_ready drops until the result drains.
// Reset (synchronous, active low) empties both registers, clears all
// press tracking state and loads the default thresholds.
`include "button_click_classifier_defines.svh"

module button_click_classifier
    import bcc_pkg::*;
#(
    parameter int TIME_BITS = 32
)(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // sample channel
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic                     i_level,
    input  logic [31:0]              i_now_ms,
    // event channel
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [1:0]               o_event_res,
    // configuration channel
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    t_cfg                 cfg;
    t_event               core_event;
    logic                 advance;

    // input register
    logic                 r_in_valid;
    logic                 r_level;
    logic [TIME_BITS-1:0] r_now;

    // result register
    logic                 r_out_valid;
    t_event               r_event;

    bcc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // the held sample moves on (and commits its state update) when the
    // result register is empty or being drained this cycle
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    // timestamp bits above TIME_BITS are dropped, narrower ones zero-extended
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_level <= i_level;
            r_now   <= TIME_BITS'(i_now_ms);
        end
    end

    bcc_core #(
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_fire  (advance),
        .i_level (r_level),
        .i_now   (r_now),
        .o_event (core_event)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_event <= core_event;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_event_res = r_event;

    `BCC_ASSERT_NEXT(a_advance_fills_out, i_clk, i_rst_n, advance, r_out_valid, "item lost between registers")
    `BCC_ASSERT_NOW(a_stall_only_full, i_clk, i_rst_n, !o_in_ready, r_in_valid && r_out_valid, "input stalled with room")
    `BCC_ASSERT_NOW(a_click_on_release, i_clk, i_rst_n, advance && core_event == EV_CLICK, r_level != cfg.pressed_level, "click while pressed")

endmodule

// ----- bench/button_click_classifier_tb.sv -----
`timescale 1ns / 1ps

module button_click_classifier_tb;
    import bcc_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 5;
    // Input register plus result register.
    localparam int PIPE_DEPTH   = 2;
    // Long output hold, enough to fill both registers and stall the input.
    localparam int HOLD_CYCLES  = 200;
    // Generous fixed limit, in ns: far beyond the slowest correct run.
    localparam longint RUN_LIMIT_NS = 64'd8_000_000;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_in_valid;
    logic                     o_in_ready;
    logic                     i_level;
    logic [31:0]              i_now_ms;
    logic                     o_out_valid;
    logic                     i_out_ready;
    logic [1:0]               o_event_res;
    logic                     i_cfg_valid;
    logic                     o_cfg_ready;
    logic [CFG_IDX_BITS-1:0]  i_cfg_index;
    logic [CFG_DATA_BITS-1:0] i_cfg_data;

    button_click_classifier i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_level     (i_level),
        .i_now_ms    (i_now_ms),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_event_res (o_event_res),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Classifier shadow: thresholds and press tracking as the block holds
    // them, advanced once per accepted sample.
    // ------------------------------------------------------------------
    t_cfg        regs;
    bit          btn_stable;        // last level that got past debounce
    bit [31:0]   last_change;       // when that sample was taken
    bit [31:0]   press_t0;
    bit          press_on;
    bit [31:0]   repeat_at;         // next long press may fire after this
    bit          repeat_on;
    bit [31:0]   release_t;
    bit          release_on;
    bit [2:0]    dbl_presses;       // saturating press count toward a double
    bit [2:0]    click_flags;       // prevent / wait / pending, package bit order
    bit [31:0]   single_ok_after;
    bit [31:0]   click_after;
    bit          long_hit;          // long press reached, held until release

    // Expected event codes, oldest first.
    t_event      due_events[$];

    int          fail_count;
    int          samples_sent;
    int          samples_taken;     // samples that got past debounce
    int          settings_used;
    int          event_tally[4];

    int          in_idle_pct;
    int          out_idle_pct;
    logic        out_hold;
    event        hold_start;

    bit [31:0]   clock_ms;          // timestamp cursor for gestures

    function automatic void reset_model();
        regs.pressed_level   = 1'b0;
        regs.debounce_ms     = 16'd20;
        regs.arm_ms          = 16'd80;
        regs.dbl_gap_ms      = 16'd30;
        regs.long_click_ms   = 16'd800;
        regs.repeat_gap_ms   = 16'd400;
        regs.suppress_long   = 1'b0;
        btn_stable      = 1'b0;
        last_change     = '0;
        press_t0        = '0;
        press_on        = 1'b0;
        repeat_at       = '0;
        repeat_on       = 1'b0;
        release_t       = '0;
        release_on      = 1'b0;
        dbl_presses     = '0;
        click_flags     = '0;
        single_ok_after = '0;
        click_after     = '0;
        long_hit        = 1'b0;
    endfunction

    // Classify one sample and advance the shadow state.
    function automatic t_event classify_sample(bit lvl, bit [31:0] now);
        bit [31:0] held;
        bit [31:0] half_click;
        bit [31:0] dbl_twice;
        t_event    ev;
        ev         = EV_NONE;
        half_click = {17'd0, regs.arm_ms[15:1]};
        dbl_twice  = {15'd0, regs.dbl_gap_ms, 1'b0};

        // level change too soon after the last accepted sample: bounce
        if (lvl != btn_stable && (now - last_change) < {16'd0, regs.debounce_ms})
            return EV_NONE;
        samples_taken++;
        btn_stable  = lvl;
        last_change = now;

        if (lvl == regs.pressed_level) begin
            if (!press_on) begin
                press_t0 = now;
                press_on = 1'b1;
                return EV_NONE;
            end
            held = now - press_t0;
            if (held > regs.long_click_ms && (!repeat_on || now > repeat_at)) begin
                repeat_at   = now + regs.repeat_gap_ms;
                repeat_on   = 1'b1;
                dbl_presses = '0;
                long_hit    = 1'b1;
                click_flags[SF_PREVENT] = 1'b1;
                click_flags[SF_PENDING] = 1'b1;
            end else if (held > regs.arm_ms && !click_flags[SF_WAIT] &&
                         !click_flags[SF_PREVENT] && now > single_ok_after) begin
                click_flags[SF_WAIT]    = 1'b1;
                click_flags[SF_PENDING] = 1'b1;
                click_after = now + half_click;
            end else if (held > regs.dbl_gap_ms && !click_flags[SF_WAIT]) begin
                if (release_on && (now - release_t) > regs.dbl_gap_ms) begin
                    single_ok_after = now + dbl_twice;
                    if (dbl_presses < DBL_COUNT_MAX)
                        dbl_presses++;
                end
                release_on = 1'b0;
            end
        end else begin
            if (now > click_after && click_flags[SF_PENDING]) begin
                dbl_presses = '0;
                ev = EV_CLICK;
            end
            release_t   = now;
            release_on  = 1'b1;
            press_on    = 1'b0;
            repeat_on   = 1'b0;
            click_flags = '0;
            long_hit    = 1'b0;
        end

        if (click_flags[SF_PENDING] && dbl_presses > 1) begin
            dbl_presses = '0;
            click_flags[SF_PREVENT] = 1'b0;
            single_ok_after = '0;
            ev = EV_DOUBLE;
        end
        // long press wins over a double click in the same sample
        if (long_hit && !regs.suppress_long && click_flags[SF_PENDING]) begin
            click_flags[SF_PREVENT] = 1'b1;
            click_flags[SF_PENDING] = 1'b0;
            repeat_at = now + regs.repeat_gap_ms;
            repeat_on = 1'b1;
            ev = EV_LONG;
        end
        return ev;
    endfunction

    // ------------------------------------------------------------------
    // Sample channel: random gaps before each item, valid held until taken.
    // Valid is left high after the handshake so back-to-back items need
    // only one assignment per edge; drain_events drops it.
    // ------------------------------------------------------------------
    task automatic send_sample(bit lvl, bit [31:0] ts);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_level    <= lvl;
        i_now_ms   <= ts;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        due_events.push_back(classify_sample(lvl, ts));
        samples_sent++;
    endtask

    // Stop offering samples and wait until every event has come back.
    task automatic drain_events();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (due_events.size() != 0)
            @(posedge i_clk);
    endtask

    // One register write; the shadow copy changes at the handshake.
    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        case (idx)
            CFG_PRESSED_LEVEL:   regs.pressed_level   = data[0];
            CFG_DEBOUNCE_MS:     regs.debounce_ms     = data;
            CFG_ARM_MS:          regs.arm_ms          = data;
            CFG_DBL_GAP_MS:      regs.dbl_gap_ms      = data;
            CFG_LONG_CLICK_MS:   regs.long_click_ms   = data;
            CFG_REPEAT_GAP_MS:   regs.repeat_gap_ms   = data;
            CFG_SUPPRESS_LONG:   regs.suppress_long   = data[0];
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
    endtask

    // Full threshold set, written only once the pipe is empty.
    task automatic load_thresholds(bit lvl, int deb, int clk, int dbl, int lng, int rpt,
                                   bit sup);
        drain_events();
        write_reg(CFG_PRESSED_LEVEL, {15'd0, lvl});
        write_reg(CFG_DEBOUNCE_MS, deb[15:0]);
        write_reg(CFG_ARM_MS, clk[15:0]);
        write_reg(CFG_DBL_GAP_MS, dbl[15:0]);
        write_reg(CFG_LONG_CLICK_MS, lng[15:0]);
        write_reg(CFG_REPEAT_GAP_MS, rpt[15:0]);
        write_reg(CFG_SUPPRESS_LONG, {15'd0, sup});
        settings_used++;
    endtask

    // One press/hold/release with random bounce, hold and gap lengths picked
    // around the current thresholds; now and then plain junk samples.
    task automatic button_gesture();
        bit        on_lvl;
        int        deb;
        int        hold_ms;
        int        gap_ms;
        int        stride;
        bit [31:0] t0;
        on_lvl = regs.pressed_level;
        deb    = int'(regs.debounce_ms);

        // junk: random levels at arbitrary timestamps
        if ($urandom_range(99) < 6) begin
            repeat ($urandom_range(4, 1)) begin
                clock_ms = $urandom();
                send_sample(1'($urandom_range(1)), clock_ms);
            end
            return;
        end
        // rare big jump, also carries the cursor across the 32-bit wrap
        if ($urandom_range(99) < 3)
            clock_ms += $urandom();

        case ($urandom_range(3))
            0: hold_ms = $urandom_range(regs.dbl_gap_ms + 1, 0);
            1: hold_ms = $urandom_range(regs.dbl_gap_ms + 1,
                                        regs.arm_ms + regs.arm_ms / 2 + 2);
            2: hold_ms = $urandom_range(regs.arm_ms, regs.long_click_ms + 1);
            default: hold_ms = $urandom_range(regs.long_click_ms + 1,
                                              regs.long_click_ms + 3 * regs.repeat_gap_ms + 2);
        endcase
        case ($urandom_range(2))
            0: gap_ms = $urandom_range(regs.dbl_gap_ms + 1, 0);
            1: gap_ms = $urandom_range(regs.dbl_gap_ms + 1,
                                       2 * regs.dbl_gap_ms + regs.arm_ms + 2);
            default: gap_ms = $urandom_range(deb, regs.long_click_ms + 1);
        endcase

        // press edge, then contact bounce inside the debounce window
        clock_ms += 1;
        t0 = clock_ms;
        send_sample(on_lvl, clock_ms);
        if (deb > 1 && $urandom_range(1)) begin
            repeat ($urandom_range(3, 1)) begin
                clock_ms += $urandom_range(1, (deb - 1) / 3 + 1);
                send_sample(~on_lvl, clock_ms);
            end
        end

        // hold, fine or coarse sampling, with a stray glitch now and then
        stride = 1 + hold_ms / ($urandom_range(1) ? 30 : 8);
        while (clock_ms - t0 < hold_ms) begin
            clock_ms += $urandom_range(1, stride);
            send_sample(($urandom_range(99) < 3) ? ~on_lvl : on_lvl, clock_ms);
        end

        // release and rest; the release may itself bounce off debounce
        t0 = clock_ms;
        stride = 1 + gap_ms / 6;
        clock_ms += $urandom_range(1, stride);
        send_sample(~on_lvl, clock_ms);
        while (clock_ms - t0 < gap_ms) begin
            clock_ms += $urandom_range(1, stride);
            send_sample(~on_lvl, clock_ms);
        end
    endtask

    task automatic run_gestures(int n_samples);
        int target;
        target = samples_taken + n_samples;
        while (samples_taken < target)
            button_gesture();
    endtask

    // ------------------------------------------------------------------
    // Directed tests, default thresholds after reset: pressed means low.
    // ------------------------------------------------------------------
    task automatic test_click_and_bounce();
        send_sample(1'b0, 32'd1000);    // first pressed sample only starts the press
        send_sample(1'b0, 32'd1100);    // held past click time: click armed
        send_sample(1'b1, 32'd1200);    // release reports the click
        send_sample(1'b0, 32'd1210);    // too soon after release: bounce
    endtask

    task automatic test_long_press_repeat();
        send_sample(1'b0, 32'd2000);
        send_sample(1'b0, 32'd2900);    // long press
        send_sample(1'b0, 32'd3400);    // repeat interval elapsed: again
        send_sample(1'b1, 32'd3500);
    endtask

    task automatic test_double_click();
        send_sample(1'b0, 32'd5000);
        send_sample(1'b0, 32'd5040);    // first counted press
        send_sample(1'b1, 32'd5060);
        send_sample(1'b0, 32'd5100);
        send_sample(1'b0, 32'd5140);    // second counted press
        send_sample(1'b0, 32'd5210);    // armed with two presses: double
        send_sample(1'b1, 32'd5300);
    endtask

    // Long press reached while suppressed, then unsuppressed mid-press.
    task automatic test_suppress_mid_press();
        drain_events();
        write_reg(CFG_SUPPRESS_LONG, 16'd1);
        send_sample(1'b0, 32'd6000);
        send_sample(1'b0, 32'd6900);    // latched but silent
        drain_events();
        write_reg(CFG_SUPPRESS_LONG, 16'd0);
        send_sample(1'b0, 32'd6950);    // latched press now reported
        send_sample(1'b1, 32'd7000);
    endtask

    task automatic test_timestamp_wrap();
        send_sample(1'b0, 32'hFFFF_FFF0);
        send_sample(1'b0, 32'h0000_0010);   // hold time across the wrap
        send_sample(1'b1, 32'hFFFF_FFFF);   // timestamp going backward
        send_sample(1'b0, 32'h0000_0000);
    endtask

    // Random small thresholds, several settings, gestures on each.
    task automatic test_random_gestures(int n_settings, int per_setting);
        repeat (n_settings) begin
            load_thresholds(1'($urandom_range(1)), $urandom_range(6, 0),
                            $urandom_range(40, 10),
                            $urandom_range(15, 3), $urandom_range(150, 40),
                            $urandom_range(60, 5), $urandom_range(99) < 25);
            if ($urandom_range(1))
                clock_ms = $urandom();
            run_gestures(per_setting);
        end
    endtask

    task automatic test_zero_thresholds();
        load_thresholds(1'b1, 0, 0, 0, 0, 0, 1'b0);
        run_gestures(100);
    endtask

    task automatic test_max_thresholds();
        load_thresholds(1'b0, 65535, 65535, 65535, 65535, 65535, 1'b1);
        clock_ms = 32'hFFF0_0000;
        run_gestures(120);
    endtask

    task automatic test_default_thresholds();
        load_thresholds(1'b0, 20, 80, 30, 800, 400, 1'b0);
        run_gestures(80);
    endtask

    // Receiver holds off for a long stretch while samples keep coming, so
    // both registers fill and the input stalls.
    task automatic test_output_backpressure();
        drain_events();
        -> hold_start;
        repeat (40) begin
            clock_ms += $urandom_range(30, 1);
            send_sample(1'($urandom_range(1)), clock_ms);
        end
    endtask

    // ------------------------------------------------------------------
    // Event checker and receiver stalls.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_event want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (due_events.size() == 0) begin
                $error("event_res: no item expected, got %0d", o_event_res);
                fail_count++;
            end else begin
                want = due_events.pop_front();
                event_tally[want]++;
                if (o_event_res !== want) begin
                    $error("event_res: expected %0d, got %0d", want, o_event_res);
                    fail_count++;
                end
            end
        end
        i_out_ready <= !out_hold && ($urandom_range(99) >= out_idle_pct);
    end

    // Long receiver hold-off, counted here in clock cycles.
    always begin
        @(hold_start);
        out_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        out_hold <= 1'b0;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        int guard;
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_level     = 1'b0;
        i_now_ms    = '0;
        i_out_ready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_PRESSED_LEVEL;
        i_cfg_data  = '0;
        out_hold    = 1'b0;
        fail_count    = 0;
        samples_sent  = 0;
        samples_taken = 0;
        settings_used = 1;
        clock_ms      = 32'd10_000;
        in_idle_pct   = 17;
        out_idle_pct  = 67;
        reset_model();

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // sender idles a little, receiver a lot
        test_click_and_bounce();
        test_long_press_repeat();
        test_double_click();
        test_suppress_mid_press();
        test_timestamp_wrap();
        test_random_gestures(4, 85);
        test_zero_thresholds();

        // the other way round
        drain_events();
        in_idle_pct  = 67;
        out_idle_pct = 17;
        test_random_gestures(4, 85);
        test_max_thresholds();

        // full rate both sides
        drain_events();
        in_idle_pct  = 0;
        out_idle_pct = 0;
        test_random_gestures(4, 85);
        test_default_thresholds();
        test_output_backpressure();

        i_in_valid <= 1'b0;
        guard = 0;
        while (due_events.size() != 0 && guard < HOLD_CYCLES * 10) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (PIPE_DEPTH + 4) @(posedge i_clk);
        if (due_events.size() != 0) begin
            $error("event_res: %0d items never came out", due_events.size());
            fail_count++;
        end

        $display("Ran %0d samples (%0d past debounce) over %0d threshold sets, with stalls",
                 samples_sent, samples_taken, settings_used);
        $display("and one long output hold; events none %0d click %0d double %0d long %0d",
                 event_tally[EV_NONE], event_tally[EV_CLICK], event_tally[EV_DOUBLE],
                 event_tally[EV_LONG]);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
